[hw/rtl/potb_pkg.sv]
// ----------------------------------------------------------------------------
// Timer bank package
// Shared widths, command and status codes, and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package potb_pkg;

   localparam int MAX_TIMERS   = 16;
   localparam int TIMER_SEL_W  = 4;
   localparam int CMD_W        = 3;
   localparam int INDEX_W      = 8;
   localparam int PERIOD_W     = 16;
   localparam int STATUS_W     = 2;
   localparam int MASK_W       = 16;
   localparam int TICK_W       = 10;
   localparam int COUNT_W      = 16;
   localparam int PRODUCT_W    = 20;
   localparam int REM_W        = TICK_W + 1;
   localparam int DIV_STEP_W   = 5;
   localparam int CSR_ADDR_W   = 8;
   localparam int CSR_DATA_W   = 16;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DEINIT  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_START   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SERVICE = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_HANDLER = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BUSY       = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_TICK_LENGTH  = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HANDLER_MASK = 8'd1;

   localparam logic [TICK_W-1:0] TICK_LENGTH_RESET = 10'd10;

   typedef struct packed {
      logic latch;
      logic exec;
      logic div_step;
      logic load_timer;
      logic walk_step;
      logic rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic start_go;
      logic tick_run;
      logic div_last;
      logic walk_last;
   } ctl_sts_type;

endpackage

[hw/rtl/potb_ifs.sv]
// ----------------------------------------------------------------------------
// Timer bank channels
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface potb_req_if;
   logic                            valid;
   logic                            ready;
   logic [potb_pkg::CMD_W-1:0]      cmd;
   logic [potb_pkg::INDEX_W-1:0]    timer_index;
   logic [potb_pkg::PERIOD_W-1:0]   period_ms;
   logic                            one_shot;

   modport source (output valid, cmd, timer_index, period_ms, one_shot, input ready);
   modport sink (input valid, cmd, timer_index, period_ms, one_shot, output ready);
endinterface

interface potb_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [potb_pkg::STATUS_W-1:0]   status;
   logic [potb_pkg::MASK_W-1:0]     fired_mask;
   logic [potb_pkg::MASK_W-1:0]     serviced_mask;
   logic                            event_raised;

   modport source (output valid, status, fired_mask, serviced_mask, event_raised,
                   input ready);
   modport sink (input valid, status, fired_mask, serviced_mask, event_raised,
                 output ready);
endinterface

interface potb_csr_if;
   logic                             valid;
   logic                             ready;
   logic [potb_pkg::CSR_ADDR_W-1:0]  index;
   logic [potb_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/potb_ctrl.sv]
// ----------------------------------------------------------------------------
// Timer bank controller
// One command at a time: latch, execute, divide and load or walk, respond.
// ----------------------------------------------------------------------------
module potb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  potb_pkg::ctl_sts_type sts,
   output potb_pkg::ctl_cmd_type ctl
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_WALK = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ctl            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            priority if (sts.start_go) begin
               state_in = ST_DIV;
            end else if (sts.tick_run) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            ctl.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctl.load_timer = 1'b1;
            state_in       = ST_DONE;
         end
         ST_WALK: begin
            ctl.walk_step = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               ctl.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/potb_dpath.sv]
// ----------------------------------------------------------------------------
// Timer bank datapath
// Timer state, registers, period divider, timer walk and result registers.
// ----------------------------------------------------------------------------
module potb_dpath #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  potb_pkg::ctl_cmd_type              ctl,
   output potb_pkg::ctl_sts_type              sts,
   input  logic [potb_pkg::CMD_W-1:0]         req_cmd,
   input  logic [potb_pkg::INDEX_W-1:0]       req_timer_index,
   input  logic [potb_pkg::PERIOD_W-1:0]      req_period_ms,
   input  logic                               req_one_shot,
   input  logic                               csr_valid,
   input  logic [potb_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [potb_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [potb_pkg::STATUS_W-1:0]      rsp_status,
   output logic [potb_pkg::MASK_W-1:0]        rsp_fired_mask,
   output logic [potb_pkg::MASK_W-1:0]        rsp_serviced_mask,
   output logic                               rsp_event_raised
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int PW    = potb_pkg::PRODUCT_W;
   localparam int TW    = potb_pkg::TICK_W;
   localparam int CW    = potb_pkg::COUNT_W;

   // registers
   logic [TW-1:0]                     tick_len_ff, tick_len_in;
   logic [potb_pkg::MASK_W-1:0]       handler_mask_ff, handler_mask_in;

   // timer state
   logic                              enabled_ff, enabled_in;
   logic [NUM_TIMERS-1:0]             active_ff, active_in;
   logic [NUM_TIMERS-1:0]             pending_ff, pending_in;
   logic [CW-1:0]                     count_ff [NUM_TIMERS];
   logic [CW-1:0]                     count_in [NUM_TIMERS];
   logic [CW-1:0]                     reload_ff [NUM_TIMERS];
   logic [CW-1:0]                     reload_in [NUM_TIMERS];

   // latched command
   logic [potb_pkg::CMD_W-1:0]        cmd_ff;
   logic [potb_pkg::INDEX_W-1:0]      index_ff;
   logic [potb_pkg::PERIOD_W-1:0]     period_ff;
   logic                              one_shot_ff;

   // working result
   logic [potb_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [NUM_TIMERS-1:0]             fired_ff, fired_in;
   logic [potb_pkg::MASK_W-1:0]       serviced_ff, serviced_in;

   // divider and walk
   logic [PW-1:0]                     quot_ff, quot_in;
   logic [potb_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [potb_pkg::DIV_STEP_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]                  walk_ff, walk_in;

   // response payload
   logic [potb_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [potb_pkg::MASK_W-1:0]       rsp_fired_ff;
   logic [potb_pkg::MASK_W-1:0]       rsp_serviced_ff;
   logic                              rsp_event_ff;

   logic [TW-1:0]                     tick_eff;
   logic [PW-1:0]                     product;
   logic                              in_range;
   logic [IDX_W-1:0]                  sel;
   logic                              handler_bit;
   logic                              too_short;
   logic [potb_pkg::STATUS_W-1:0]     start_status;
   logic [potb_pkg::STATUS_W-1:0]     stop_status;
   logic [NUM_TIMERS-1:0]             hmask_n;
   logic [potb_pkg::REM_W-1:0]        rem_shift;
   logic [potb_pkg::REM_W-1:0]        divisor;
   logic                              fits;
   logic [CW-1:0]                     cur_cnt;
   logic [CW-1:0]                     cur_reload;
   logic [CW-1:0]                     cur_dec;

   // zero tick length counts as one
   assign tick_eff = (tick_len_ff == '0) ? TW'(1) : tick_len_ff;
   assign product  = (PW'(period_ff) << 3) + (PW'(period_ff) << 1);
   assign in_range = (index_ff < potb_pkg::INDEX_W'(NUM_TIMERS));
   assign sel      = index_ff[IDX_W-1:0];
   assign handler_bit = handler_mask_ff[index_ff[potb_pkg::TIMER_SEL_W-1:0]];
   assign too_short   = (product < PW'(tick_eff));
   assign hmask_n     = handler_mask_ff[NUM_TIMERS-1:0];

   always_comb begin
      priority if (!in_range || too_short) begin
         start_status = potb_pkg::STATUS_RANGE;
      end else if (!handler_bit) begin
         start_status = potb_pkg::STATUS_NO_HANDLER;
      end else if (!enabled_ff || active_ff[sel]) begin
         start_status = potb_pkg::STATUS_BUSY;
      end else begin
         start_status = potb_pkg::STATUS_OK;
      end
   end

   always_comb begin
      priority if (!in_range) begin
         stop_status = potb_pkg::STATUS_RANGE;
      end else if (!enabled_ff) begin
         stop_status = potb_pkg::STATUS_BUSY;
      end else begin
         stop_status = potb_pkg::STATUS_OK;
      end
   end

   assign sts.start_go  = (cmd_ff == potb_pkg::CMD_START) && (start_status == potb_pkg::STATUS_OK);
   assign sts.tick_run  = (cmd_ff == potb_pkg::CMD_TICK) && enabled_ff;
   assign sts.div_last  = (step_ff == potb_pkg::DIV_STEP_W'(PW - 1));
   assign sts.walk_last = (walk_ff == IDX_W'(NUM_TIMERS - 1));

   // register writes
   always_comb begin
      tick_len_in     = tick_len_ff;
      handler_mask_in = handler_mask_ff;
      if (csr_valid) begin
         if (csr_index == potb_pkg::CSR_TICK_LENGTH) begin
            tick_len_in = csr_data[TW-1:0];
         end
         if (csr_index == potb_pkg::CSR_HANDLER_MASK) begin
            handler_mask_in = csr_data;
         end
      end
   end

   // restoring divider, one quotient bit per step
   assign divisor   = potb_pkg::REM_W'(tick_eff);
   assign rem_shift = {rem_ff[TW-1:0], quot_ff[PW-1]};
   assign fits      = (rem_shift >= divisor);

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (ctl.exec) begin
         quot_in = product;
         rem_in  = '0;
         step_in = '0;
      end else if (ctl.div_step) begin
         quot_in = {quot_ff[PW-2:0], fits};
         rem_in  = fits ? (rem_shift - divisor) : rem_shift;
         step_in = step_ff + 1'b1;
      end
   end

   // timer walk reads one slot per cycle
   assign cur_cnt    = count_ff[walk_ff];
   assign cur_reload = reload_ff[walk_ff];
   assign cur_dec    = cur_cnt - 1'b1;

   always_comb begin
      enabled_in  = enabled_ff;
      active_in   = active_ff;
      pending_in  = pending_ff;
      count_in    = count_ff;
      reload_in   = reload_ff;
      status_in   = status_ff;
      fired_in    = fired_ff;
      serviced_in = serviced_ff;
      walk_in     = walk_ff;
      if (ctl.latch) begin
         status_in   = potb_pkg::STATUS_OK;
         fired_in    = '0;
         serviced_in = '0;
      end
      if (ctl.exec) begin
         walk_in = '0;
         unique case (cmd_ff)
            potb_pkg::CMD_INIT: begin
               // counts and reloads of idle timers are never read
               active_in  = '0;
               pending_in = '0;
               enabled_in = 1'b1;
            end
            potb_pkg::CMD_DEINIT: begin
               enabled_in = 1'b0;
            end
            potb_pkg::CMD_START: begin
               status_in = start_status;
            end
            potb_pkg::CMD_STOP: begin
               status_in = stop_status;
               if (stop_status == potb_pkg::STATUS_OK) begin
                  active_in[sel] = 1'b0;
               end
            end
            potb_pkg::CMD_SERVICE: begin
               if (enabled_ff) begin
                  pending_in  = pending_ff & ~hmask_n;
                  serviced_in = potb_pkg::MASK_W'(pending_ff & hmask_n);
               end
            end
            default: begin
            end
         endcase
      end
      if (ctl.load_timer) begin
         count_in[sel]   = quot_ff[CW-1:0];
         reload_in[sel]  = one_shot_ff ? '0 : quot_ff[CW-1:0];
         pending_in[sel] = 1'b0;
         active_in[sel]  = 1'b1;
      end
      if (ctl.walk_step) begin
         walk_in = walk_ff + 1'b1;
         if (active_ff[walk_ff] && (cur_cnt != '0)) begin
            if (cur_dec == '0) begin
               pending_in[walk_ff] = 1'b1;
               fired_in[walk_ff]   = 1'b1;
               if (cur_reload == '0) begin
                  active_in[walk_ff] = 1'b0;
               end else begin
                  count_in[walk_ff] = cur_reload;
               end
            end else begin
               count_in[walk_ff] = cur_dec;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_len_ff     <= potb_pkg::TICK_LENGTH_RESET;
         handler_mask_ff <= '0;
         enabled_ff      <= 1'b0;
         active_ff       <= '0;
         pending_ff      <= '0;
      end else begin
         tick_len_ff     <= tick_len_in;
         handler_mask_ff <= handler_mask_in;
         enabled_ff      <= enabled_in;
         active_ff       <= active_in;
         pending_ff      <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      reload_ff   <= reload_in;
      status_ff   <= status_in;
      fired_ff    <= fired_in;
      serviced_ff <= serviced_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      walk_ff     <= walk_in;
      if (ctl.latch) begin
         cmd_ff      <= req_cmd;
         index_ff    <= req_timer_index;
         period_ff   <= req_period_ms;
         one_shot_ff <= req_one_shot;
      end
      if (ctl.rsp_load) begin
         rsp_status_ff   <= status_ff;
         rsp_fired_ff    <= potb_pkg::MASK_W'(fired_ff);
         rsp_serviced_ff <= serviced_ff;
         rsp_event_ff    <= |fired_ff;
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_fired_mask    = rsp_fired_ff;
   assign rsp_serviced_mask = rsp_serviced_ff;
   assign rsp_event_raised  = rsp_event_ff;

endmodule

[hw/rtl/periodic_oneshot_timer_bank.sv]
// ----------------------------------------------------------------------------
// Periodic / one-shot timer bank
// Bank of NUM_TIMERS command-driven timers with a registered result path.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  - one command beat: init, deinit, start, stop, tick or service,
//             with timer index, period in ms and the one-shot flag.
//   rsp_ch  - exactly one result beat per command: status, fired mask,
//             serviced mask and the event flag.
//   csr_ch  - register writes (tick length, handler mask); always ready.
//             Write only while no command is in flight.
// Steps (accept to result valid, one command in flight at a time):
//   start with passing checks : exec, 20-step period divider, timer load, done
//   tick on an enabled bank   : exec, timer walk (one timer per cycle), done
//   any other command         : exec, done
//   req_ch.ready returns in the same cycle the result beat becomes valid.
// Reset clears the bank to disabled, all timers idle, tick length 10 and
// handler mask 0. A stalled rsp_ch holds its beat; the next command is still
// taken and runs, then waits in its final state until the result slot frees.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank #(
   parameter int NUM_TIMERS = 16
) (
   input  logic       clock,
   input  logic       reset,
   potb_req_if.sink   req_ch,
   potb_rsp_if.source rsp_ch,
   potb_csr_if.sink   csr_ch
);

   potb_pkg::ctl_cmd_type ctl;
   potb_pkg::ctl_sts_type sts;

   // register writes never stall
   assign csr_ch.ready = 1'b1;

   // controller: sequences the command and owns the result handshake
   potb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // datapath: timer state, divider, walk and the result payload register
   potb_dpath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_cmd           (req_ch.cmd),
      .req_timer_index   (req_ch.timer_index),
      .req_period_ms     (req_ch.period_ms),
      .req_one_shot      (req_ch.one_shot),
      .csr_valid         (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_status        (rsp_ch.status),
      .rsp_fired_mask    (rsp_ch.fired_mask),
      .rsp_serviced_mask (rsp_ch.serviced_mask),
      .rsp_event_raised  (rsp_ch.event_raised)
   );

endmodule

[hw/rtl/potb_checker.sv]
// ----------------------------------------------------------------------------
// Timer bank checker
// Port-level assertions, attached to the top level by bind.
// ----------------------------------------------------------------------------
module potb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [potb_pkg::STATUS_W-1:0]     rsp_status,
   input logic [potb_pkg::MASK_W-1:0]       rsp_fired_mask,
   input logic [potb_pkg::MASK_W-1:0]       rsp_serviced_mask,
   input logic                              rsp_event_raised
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_fired_mask) && $stable(rsp_serviced_mask)
         && $stable(rsp_event_raised))
      else $error("result beat changed while stalled");

   // one command in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while another is in flight");

   a_event_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_raised == (rsp_fired_mask != '0)))
      else $error("event flag disagrees with fired mask");

   // masks come only from tick or service, which always succeed
   a_masks_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status != potb_pkg::STATUS_OK)
         || (rsp_fired_mask != '0)) |-> (rsp_serviced_mask == '0))
      else $error("serviced mask set on a failed command or a tick");

endmodule

bind periodic_oneshot_timer_bank potb_checker u_potb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_fired_mask    (rsp_ch.fired_mask),
   .rsp_serviced_mask (rsp_ch.serviced_mask),
   .rsp_event_raised  (rsp_ch.event_raised)
);
